@@ sv/conveyor_object_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// conveyor object tracker assertion macros
// shared concurrent assertion forms for the tracker
// ----------------------------------------------------------------------------
`ifndef CONVEYOR_OBJECT_TRACKER_MACROS_SVH
`define CONVEYOR_OBJECT_TRACKER_MACROS_SVH

// same-cycle implication
`define COT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// next-cycle implication
`define COT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

@@ sv/cot_pkg.sv @@
// ----------------------------------------------------------------------------
// cot_pkg
// types, constants and the sensor debounce function of the tracker
// ----------------------------------------------------------------------------
package cot_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int DIST_W = 12;
    localparam int TIME_W = 32;
    localparam int POS_W  = 8;
    localparam int CNT_W  = 4;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX = 4'd15;
    localparam logic [DIST_W:0]   POS_LIMIT = 13'd200;
    localparam logic [DIST_W-1:0] LOWEST_RST = 12'hFFF;

    localparam logic [CFG_IW-1:0] REG_NO_OBJECT_CUTOFF = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CONVEYOR_OFFSET  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_NEAR_DELAY       = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FAR_DELAY        = 3'd3;
    localparam logic [CFG_IW-1:0] REG_GRACE_TIME       = 3'd4;
    localparam logic [CFG_IW-1:0] REG_CHANGE_CUTOFF    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SENSE0,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RETIME,
        S_SENSE1,
        S_POP_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              seeing;
        logic [CNT_W-1:0]  count;
        logic              reported;
        logic [DIST_W-1:0] lowest;
        logic [TIME_W-1:0] ltime;
    } t_sensor;

    typedef struct packed {
        t_sensor nxt;
        logic    report;
    } t_sense_res;

    typedef struct packed {
        logic latch;
        logic sense0;
        logic scan_rd;
        logic scan_cmp;
        logic retime_wr;
        logic sense1;
        logic pop;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic retime_req;
        logic scan_last;
        logic count_zero;
        logic head_expired;
        logic out_free;
    } t_stat;

    function automatic t_sense_res sensor_step(
        input t_sensor           s,
        input logic [DIST_W-1:0] d,
        input logic [TIME_W-1:0] t,
        input logic [DIST_W-1:0] cutoff,
        input logic [CNT_W-1:0]  chg
    );
        t_sense_res r;
        r.nxt    = s;
        r.report = 1'b0;
        if (s.seeing && (d < s.lowest)) begin
            r.nxt.lowest = d;
            r.nxt.ltime  = t;
            r.nxt.count  = '0;
        end else if (s.seeing || (d < cutoff)) begin
            if (s.count < COUNT_MAX) begin
                r.nxt.count = s.count + 4'd1;
            end
        end else begin
            r.nxt.count = '0;
        end
        if (r.nxt.count > chg) begin
            if (s.seeing) begin
                if (!s.reported) begin
                    r.report       = 1'b1;
                    r.nxt.reported = 1'b1;
                end
                r.nxt.lowest = cutoff;
                if (d > cutoff) begin
                    r.nxt.seeing = 1'b0;
                    r.nxt.count  = '0;
                end
            end else begin
                r.nxt.reported = 1'b0;
                r.nxt.seeing   = 1'b1;
                r.nxt.count    = '0;
            end
        end
        return r;
    endfunction

endpackage

@@ sv/cot_ctrl.sv @@
// ----------------------------------------------------------------------------
// cot_ctrl
// sequencer: near sensor, retime scan, far sensor, head removal, result
// ----------------------------------------------------------------------------
module cot_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  cot_pkg::t_stat i_stat,
    output cot_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import cot_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SENSE0;
            end
            S_SENSE0: begin
                n_state = i_stat.retime_req ? S_SCAN_RD : S_SENSE1;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_state = i_stat.scan_last ? S_RETIME : S_SCAN_RD;
            end
            S_RETIME: begin
                n_state = S_SENSE1;
            end
            S_SENSE1: begin
                n_state = S_POP_RD;
            end
            S_POP_RD: begin
                n_state = i_stat.count_zero ? S_DONE : S_POP_CMP;
            end
            S_POP_CMP: begin
                n_state = i_stat.head_expired ? S_POP_RD : S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            S_SENSE0:   o_cmd.sense0    = 1'b1;
            S_SCAN_RD:  o_cmd.scan_rd   = 1'b1;
            S_SCAN_CMP: o_cmd.scan_cmp  = 1'b1;
            S_RETIME:   o_cmd.retime_wr = 1'b1;
            S_SENSE1:   o_cmd.sense1    = 1'b1;
            S_POP_RD: begin
            end
            S_POP_CMP:  o_cmd.pop       = i_stat.head_expired;
            S_DONE:     o_cmd.out_load  = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

@@ sv/cot_dp.sv @@
// ----------------------------------------------------------------------------
// cot_dp
// sensor state, configuration, entry queue memory and result register
// ----------------------------------------------------------------------------
module cot_dp #(
    parameter int QUEUE_DEPTH = cot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cot_pkg::t_cmd               i_cmd,
    output cot_pkg::t_stat              o_stat,
    input  logic                        i_cfg_valid,
    input  logic [cot_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [cot_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic [cot_pkg::DIST_W-1:0]  i_near_distance,
    input  logic [cot_pkg::DIST_W-1:0]  i_far_distance,
    input  logic [cot_pkg::TIME_W-1:0]  i_now_time,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_head_valid,
    output logic [cot_pkg::POS_W-1:0]   o_head_position,
    output logic [cot_pkg::TIME_W-1:0]  o_head_time,
    output logic                        o_overflow
);
    import cot_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    // configuration
    logic [DIST_W-1:0] r_cutoff;
    logic [DIST_W-1:0] r_offset;
    logic [15:0]       r_near_delay;
    logic [15:0]       r_far_delay;
    logic [7:0]        r_grace;
    logic [CNT_W-1:0]  r_chg;

    // latched word
    logic [DIST_W-1:0] r_near;
    logic [DIST_W-1:0] r_far;
    logic [TIME_W-1:0] r_now;
    logic              r_dropped;

    t_sensor r_sens0;
    t_sensor r_sens1;
    t_sense_res res0;
    t_sense_res res1;

    // queue control
    logic [IW-1:0]     r_head;
    logic [IW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_ptr;
    logic [CW-1:0]     r_k;
    logic [IW-1:0]     r_best;
    logic [TIME_W-1:0] r_best_diff;
    logic              r_found;
    logic [TIME_W-1:0] r_when;

    // memory
    logic [POS_W-1:0]  mem_pos  [QUEUE_DEPTH];
    logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];
    logic [POS_W-1:0]  r_rd_pos;
    logic [TIME_W-1:0] r_rd_time;
    logic [IW-1:0]     rd_addr;

    logic              push_en;
    logic [DIST_W:0]   pos_diff;
    logic [POS_W-1:0]  push_pos;
    logic [TIME_W-1:0] push_time;
    logic [TIME_W-1:0] when0;
    logic [TIME_W-1:0] scan_diff;
    logic [TIME_W:0]   limit;

    logic              r_out_valid;
    logic              r_out_head_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_overflow;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
        return (v == IDX_LAST) ? '0 : v + IW'(1);
    endfunction

    assign res0 = sensor_step(r_sens0, r_near, r_now, r_cutoff, r_chg);
    assign res1 = sensor_step(r_sens1, r_far, r_now, r_cutoff, r_chg);

    assign when0     = r_sens0.ltime + {16'b0, r_near_delay};
    assign push_time = r_sens1.ltime + {16'b0, r_far_delay};
    assign pos_diff  = {1'b0, r_sens1.lowest} - {1'b0, r_offset};
    assign push_pos  = (pos_diff[DIST_W] || (pos_diff > POS_LIMIT)) ? '0 : pos_diff[POS_W-1:0];
    assign push_en   = i_cmd.sense1 && res1.report && (r_count != CNT_FULL);
    assign scan_diff = (r_rd_time >= r_when) ? (r_rd_time - r_when) : (r_when - r_rd_time);
    assign limit     = {1'b0, r_now} + {25'b0, r_grace};
    assign rd_addr   = i_cmd.scan_rd ? r_ptr : r_head;

    assign o_stat.retime_req   = res0.report && (r_count != '0);
    assign o_stat.scan_last    = (r_k == (r_count - CW'(1)));
    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.head_expired = ({1'b0, r_rd_time} <= limit);
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff     <= 12'd2000;
            r_offset     <= '0;
            r_near_delay <= '0;
            r_far_delay  <= '0;
            r_grace      <= 8'd10;
            r_chg        <= 4'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NO_OBJECT_CUTOFF: r_cutoff     <= i_cfg_data[DIST_W-1:0];
                REG_CONVEYOR_OFFSET:  r_offset     <= i_cfg_data[DIST_W-1:0];
                REG_NEAR_DELAY:       r_near_delay <= i_cfg_data;
                REG_FAR_DELAY:        r_far_delay  <= i_cfg_data;
                REG_GRACE_TIME:       r_grace      <= i_cfg_data[7:0];
                REG_CHANGE_CUTOFF:    r_chg        <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_near <= i_near_distance;
            r_far  <= i_far_distance;
            r_now  <= i_now_time;
        end
        if (i_cmd.sense0) begin
            r_when <= when0;
            r_ptr  <= r_head;
        end else if (i_cmd.scan_cmp) begin
            r_ptr <= idx_inc(r_ptr);
        end
        if (i_cmd.scan_cmp && (!r_found || (scan_diff < r_best_diff))) begin
            r_best      <= r_ptr;
            r_best_diff <= scan_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens0   <= '{1'b0, '0, 1'b0, LOWEST_RST, '0};
            r_sens1   <= '{1'b0, '0, 1'b0, LOWEST_RST, '0};
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_found   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.latch) r_dropped <= 1'b0;
            if (i_cmd.sense0) begin
                r_sens0 <= res0.nxt;
                r_k     <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_cmp) begin
                r_k     <= r_k + CW'(1);
                r_found <= 1'b1;
            end
            if (i_cmd.sense1) begin
                r_sens1 <= res1.nxt;
                if (res1.report && (r_count == CNT_FULL)) r_dropped <= 1'b1;
            end
            if (push_en) begin
                r_tail  <= idx_inc(r_tail);
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_head  <= idx_inc(r_head);
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            mem_pos[r_tail]  <= push_pos;
            mem_time[r_tail] <= push_time;
        end else if (i_cmd.retime_wr) begin
            mem_time[r_best] <= r_when;
        end
        r_rd_pos  <= mem_pos[rd_addr];
        r_rd_time <= mem_time[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_head_valid <= (r_count != '0);
            r_out_pos        <= (r_count != '0) ? r_rd_pos : '0;
            r_out_time       <= (r_count != '0) ? r_rd_time : '0;
            r_out_overflow   <= r_dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_head_valid    = r_out_head_valid;
    assign o_head_position = r_out_pos;
    assign o_head_time     = r_out_time;
    assign o_overflow      = r_out_overflow;

endmodule

@@ sv/conveyor_object_tracker.sv @@
// sequence: an accepted word passes the near sensor step, then, when the near sensor
//   reports into a non-empty queue, a scan for the nearest entry and its retime, then the
//   far sensor step, removal of expired head entries and the registered result load
// input is stalled from accept until the result is loaded, so no new word is taken meanwhile
// reset: synchronous active-low, clears sensors, queue pointers and registers to defaults;
//   queue memory contents are not cleared
// ----------------------------------------------------------------------------
// conveyor_object_tracker
// debounced two-sensor object tracker with a timed position queue
// ----------------------------------------------------------------------------
`include "conveyor_object_tracker_macros.svh"

module conveyor_object_tracker #(
    parameter int QUEUE_DEPTH = cot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cot_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [cot_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cot_pkg::DIST_W-1:0]  i_near_distance,
    input  logic [cot_pkg::DIST_W-1:0]  i_far_distance,
    input  logic [cot_pkg::TIME_W-1:0]  i_now_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_head_valid,
    output logic [cot_pkg::POS_W-1:0]   o_head_position,
    output logic [cot_pkg::TIME_W-1:0]  o_head_time,
    output logic                        o_overflow
);
    import cot_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cot_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_near_distance (i_near_distance),
        .i_far_distance  (i_far_distance),
        .i_now_time      (i_now_time),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_head_valid    (o_head_valid),
        .o_head_position (o_head_position),
        .o_head_time     (o_head_time),
        .o_overflow      (o_overflow)
    );

    `COT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `COT_ASSERT_IMPL(a_empty_head_zero, i_clk, i_rst_n, o_out_valid && !o_head_valid, (o_head_position == '0) && (o_head_time == '0))
    `COT_ASSERT_IMPL(a_position_range, i_clk, i_rst_n, o_out_valid, o_head_position <= POS_W'(200))

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the conveyor object tracker: a driver and a monitor
// run as clocked processes, every accepted sample is run through an in-bench
// copy of the tracker, and each result word is compared against the oldest
// predicted head word, over several register settings and idle patterns
// ----------------------------------------------------------------------------
module tb;
    import cot_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int POS_MAX        = 200;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NEAR_SENSOR    = 0;
    localparam int FAR_SENSOR     = 1;

    localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0] near_d;
        logic [DIST_W-1:0] far_d;
        logic [TIME_W-1:0] stamp;
    } t_sample;

    typedef struct packed {
        logic              present;
        logic [POS_W-1:0]  pos;
        logic [TIME_W-1:0] due;
        logic              dropped;
    } t_head_word;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic [DIST_W-1:0] near_d    = '0;
    logic [DIST_W-1:0] far_d     = '0;
    logic [TIME_W-1:0] now_t     = '0;
    logic              out_stall = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_head_valid;
    logic [POS_W-1:0]  o_head_position;
    logic [TIME_W-1:0] o_head_time;
    logic              o_overflow;

    conveyor_object_tracker uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_near_distance (near_d),
        .i_far_distance  (far_d),
        .i_now_time      (now_t),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_head_valid    (o_head_valid),
        .o_head_position (o_head_position),
        .o_head_time     (o_head_time),
        .o_overflow      (o_overflow)
    );

    // tracker copy: registers
    logic [DIST_W-1:0] cfg_cutoff;
    logic [DIST_W-1:0] cfg_offset;
    logic [15:0]       cfg_near_delay;
    logic [15:0]       cfg_far_delay;
    logic [7:0]        cfg_grace;
    logic [CNT_W-1:0]  cfg_change;

    // tracker copy: sensors and entry queue
    logic              seen_obj [2];
    logic [CNT_W-1:0]  deb_cnt  [2];
    logic              rep_done [2];
    logic [DIST_W-1:0] low_dist [2];
    logic [TIME_W-1:0] low_time [2];
    logic [POS_W-1:0]  q_pos  [DEPTH];
    logic [TIME_W-1:0] q_time [DEPTH];
    int                q_head;
    int                q_tail;
    int                q_count;
    logic              now_dropped;

    t_sample    sample_q [$];
    t_head_word head_expect_q [$];
    t_sample    drv_word;
    t_head_word drv_result;
    t_head_word mon_want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_tickets   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;
    int mismatch_count = 0;

    // traffic generator state
    bit                obj_in   [2];
    int                run_left [2];
    logic [DIST_W-1:0] low_pick [2];
    logic [TIME_W-1:0] now_clk;

    initial begin
        forever #2 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        case (idx)
            REG_NO_OBJECT_CUTOFF: cfg_cutoff     = val[DIST_W-1:0];
            REG_CONVEYOR_OFFSET:  cfg_offset     = val[DIST_W-1:0];
            REG_NEAR_DELAY:       cfg_near_delay = val;
            REG_FAR_DELAY:        cfg_far_delay  = val;
            REG_GRACE_TIME:       cfg_grace      = val[7:0];
            REG_CHANGE_CUTOFF:    cfg_change     = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reset_tracker();
        cfg_cutoff     = 12'd2000;
        cfg_offset     = '0;
        cfg_near_delay = '0;
        cfg_far_delay  = '0;
        cfg_grace      = 8'd10;
        cfg_change     = 4'd10;
        for (int s = 0; s < 2; s++) begin
            seen_obj[s] = 1'b0;
            deb_cnt[s]  = '0;
            rep_done[s] = 1'b0;
            low_dist[s] = '1;
            low_time[s] = '0;
            obj_in[s]   = 1'b0;
            run_left[s] = 0;
            low_pick[s] = '0;
        end
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
        now_clk = '0;
    endtask

    task automatic enqueue_entry(input logic [DIST_W-1:0] low, input logic [TIME_W-1:0] due);
        int p;
        p = int'(low) - int'(cfg_offset);
        if (q_count >= DEPTH) begin
            now_dropped = 1'b1;
        end else begin
            if (p < 0 || p > POS_MAX) begin
                p = 0;
            end
            q_pos[q_tail]  = p[POS_W-1:0];
            q_time[q_tail] = due;
            q_tail         = (q_tail + 1) % DEPTH;
            q_count++;
        end
    endtask

    task automatic retime_nearest(input logic [TIME_W-1:0] due);
        int          idx;
        int          best;
        logic [31:0] diff;
        logic [31:0] best_diff;
        bit          found;
        best      = 0;
        best_diff = '0;
        found     = 1'b0;
        for (int k = 0; k < q_count; k++) begin
            idx  = (q_head + k) % DEPTH;
            diff = (q_time[idx] >= due) ? q_time[idx] - due : due - q_time[idx];
            if (!found || diff < best_diff) begin
                found     = 1'b1;
                best      = idx;
                best_diff = diff;
            end
        end
        if (found) begin
            q_time[best] = due;
        end
    endtask

    task automatic sense_update(input int s, input logic [DIST_W-1:0] d,
                                input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] due;
        if (seen_obj[s] && d < low_dist[s]) begin
            low_dist[s] = d;
            low_time[s] = t;
            deb_cnt[s]  = '0;
        end else if (seen_obj[s] || d < cfg_cutoff) begin
            if (deb_cnt[s] != COUNT_MAX) begin
                deb_cnt[s] = deb_cnt[s] + 4'd1;
            end
        end else begin
            deb_cnt[s] = '0;
        end
        if (deb_cnt[s] > cfg_change) begin
            if (seen_obj[s]) begin
                if (!rep_done[s]) begin
                    if (s == FAR_SENSOR) begin
                        due = low_time[s] + {16'b0, cfg_far_delay};
                        enqueue_entry(low_dist[s], due);
                    end else begin
                        due = low_time[s] + {16'b0, cfg_near_delay};
                        retime_nearest(due);
                    end
                    rep_done[s] = 1'b1;
                end
                low_dist[s] = cfg_cutoff;
                if (d > cfg_cutoff) begin
                    seen_obj[s] = 1'b0;
                    deb_cnt[s]  = '0;
                end
            end else begin
                rep_done[s] = 1'b0;
                seen_obj[s] = 1'b1;
                deb_cnt[s]  = '0;
            end
        end
    endtask

    task automatic track_step(input t_sample w, output t_head_word r);
        logic [TIME_W:0] limit;
        now_dropped = 1'b0;
        sense_update(NEAR_SENSOR, w.near_d, w.stamp);
        sense_update(FAR_SENSOR, w.far_d, w.stamp);
        limit = {1'b0, w.stamp} + {25'b0, cfg_grace};
        while (q_count > 0 && {1'b0, q_time[q_head]} <= limit) begin
            q_head = (q_head + 1) % DEPTH;
            q_count--;
        end
        if (q_count > 0) begin
            r.present = 1'b1;
            r.pos     = q_pos[q_head];
            r.due     = q_time[q_head];
        end else begin
            r.present = 1'b0;
            r.pos     = '0;
            r.due     = '0;
        end
        r.dropped = now_dropped;
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic load_settings(input logic [15:0] cutoff, input logic [15:0] offset,
                                 input logic [15:0] nd, input logic [15:0] fd,
                                 input logic [15:0] grace, input logic [15:0] chg);
        write_reg(REG_NO_OBJECT_CUTOFF, cutoff);
        write_reg(REG_CONVEYOR_OFFSET, offset);
        write_reg(REG_NEAR_DELAY, nd);
        write_reg(REG_FAR_DELAY, fd);
        write_reg(REG_GRACE_TIME, grace);
        write_reg(REG_CHANGE_CUTOFF, chg);
    endtask

    task automatic push_sample(input logic [DIST_W-1:0] nd, input logic [DIST_W-1:0] fd,
                               input logic [TIME_W-1:0] t);
        t_sample w;
        w.near_d = nd;
        w.far_d  = fd;
        w.stamp  = t;
        sample_q.push_back(w);
    endtask

    // objects passing both sensors with random run lengths, plus some noise
    task automatic queue_traffic(input int n, input int tstep);
        logic [DIST_W-1:0] d [2];
        int                cand;
        for (int i = 0; i < n; i++) begin
            for (int s = 0; s < 2; s++) begin
                if (run_left[s] == 0) begin
                    obj_in[s]   = !obj_in[s];
                    run_left[s] = int'($urandom_range(cfg_change + 1, 3 * cfg_change + 8));
                    low_pick[s] = '0;
                    if (cfg_cutoff != 0) begin
                        low_pick[s] = DIST_W'($urandom_range(0, cfg_cutoff - 1));
                        cand = int'(cfg_offset) + int'($urandom_range(0, 220));
                        if ($urandom_range(1) == 1 && cand < int'(cfg_cutoff)) begin
                            low_pick[s] = DIST_W'(cand);
                        end
                    end
                end
                run_left[s]--;
                if ($urandom_range(9) == 0) begin
                    d[s] = DIST_W'($urandom_range(0, 4095));
                end else if (obj_in[s] && cfg_cutoff != 0) begin
                    d[s] = DIST_W'($urandom_range(low_pick[s], cfg_cutoff - 1));
                end else if (cfg_cutoff >= 12'hFFF) begin
                    d[s] = 12'hFFF;
                end else begin
                    d[s] = DIST_W'($urandom_range(cfg_cutoff + 1, 4095));
                end
            end
            now_clk = now_clk + $urandom_range(0, tstep);
            push_sample(d[0], d[1], now_clk);
        end
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || in_valid || head_expect_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [15:0] rnd_chg;
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, field extremes
        push_sample(12'd0, 12'd0, 32'd0);
        push_sample(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        push_sample(12'd0, 12'hFFF, 32'd7);
        push_sample(12'hFFF, 12'd0, 32'd8);
        drain();

        // directed: near report into empty queue, position edges, tie, removal
        load_settings(16'd2000, 16'd100, 16'd50, 16'd1000, 16'd10, 16'd0);
        push_sample(12'd1500, 12'hFFF, 32'd1);
        push_sample(12'd300, 12'hFFF, 32'd2);
        push_sample(12'hFFF, 12'hFFF, 32'd3);
        push_sample(12'hFFF, 12'd1500, 32'd10);
        push_sample(12'hFFF, 12'd150, 32'd20);
        push_sample(12'hFFF, 12'hFFF, 32'd30);
        push_sample(12'hFFF, 12'd1500, 32'd40);
        push_sample(12'hFFF, 12'd300, 32'd50);
        push_sample(12'hFFF, 12'hFFF, 32'd60);
        push_sample(12'hFFF, 12'd1500, 32'd70);
        push_sample(12'hFFF, 12'd301, 32'd80);
        push_sample(12'hFFF, 12'hFFF, 32'd90);
        push_sample(12'hFFF, 12'd1500, 32'd100);
        push_sample(12'hFFF, 12'd0, 32'd110);
        push_sample(12'hFFF, 12'hFFF, 32'd120);
        push_sample(12'd1500, 12'hFFF, 32'd1000);
        push_sample(12'd200, 12'hFFF, 32'd1015);
        push_sample(12'hFFF, 12'hFFF, 32'd1030);
        push_sample(12'hFFF, 12'hFFF, 32'd1100);
        drain();

        // receiver hold-off while the sender keeps offering
        load_settings(16'd2000, 16'd0, 16'd20, 16'd40, 16'd10, 16'd1);
        hold_tickets++;
        queue_traffic(150, 8);
        drain();

        // queue fills and drops far entries
        send_idle_pct = 79;
        load_settings(16'd3000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        queue_traffic(200, 1);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 79;
        load_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFF, 16'd14);
        now_clk = 32'hFFFF_FF00;
        queue_traffic(130, 4);
        drain();

        // sensors frozen
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        load_settings(16'($urandom_range(500, 3500)), 16'($urandom_range(0, 300)),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'd15);
        queue_traffic(60, 10);
        drain();

        rnd_chg      = 16'($urandom);
        rnd_chg[3:0] = 4'($urandom_range(0, 3));
        load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), rnd_chg);
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
        now_clk = $urandom;
        queue_traffic(120, 20);
        drain();

        load_settings(16'd0, 16'd200, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_traffic(30, 5);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_settings(16'd1200, 16'd50, 16'd100, 16'd300, 16'd30, 16'd2);
        now_clk = 32'hFFFF_FE00;
        queue_traffic(100, 6);
        drain();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_step(drv_word, drv_result);
                head_expect_q.push_back(drv_result);
            end
            if (!in_valid || !o_in_stall) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_word = sample_q.pop_front();
                    in_valid <= 1'b1;
                    near_d   <= drv_word.near_d;
                    far_d    <= drv_word.far_d;
                    now_t    <= drv_word.stamp;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (head_expect_q.size() == 0) begin
                    note_mismatch("unexpected word", 32'd1, 32'd0);
                end else begin
                    mon_want = head_expect_q.pop_front();
                    if (o_head_valid !== mon_want.present) begin
                        note_mismatch("head_valid", 32'(o_head_valid), 32'(mon_want.present));
                    end
                    if (o_head_position !== mon_want.pos) begin
                        note_mismatch("head_position", 32'(o_head_position),
                                      32'(mon_want.pos));
                    end
                    if (o_head_time !== mon_want.due) begin
                        note_mismatch("head_time", o_head_time, mon_want.due);
                    end
                    if (o_overflow !== mon_want.dropped) begin
                        note_mismatch("overflow", 32'(o_overflow), 32'(mon_want.dropped));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_served != hold_tickets) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
